// ----- hdl/epwr_pkg.sv -----
// ----------------------------------------------------------------------------
// echo pulse width ranger package
// shared types and constants for the echo pulse ranger
// ----------------------------------------------------------------------------
package epwr_pkg;

  // action codes of an input word
  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_OVERFLOW = 2'd1,
    ACT_RISE    = 2'd2,
    ACT_FALL    = 2'd3
  } action_t;

  // configuration register indexes
  typedef enum logic {
    REG_PERIOD    = 1'b0,
    REG_PRESCALER = 1'b1
  } reg_index_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_TICKS,
    S_RATE,
    S_LOAD,
    S_MS,
    S_DIST
  } state_t;

  localparam int OVF_W   = 8;
  localparam int TICKS_W = 25;
  localparam int NUM_W   = 34;
  localparam int DEN_W   = 27;
  localparam int MS_W    = 22;
  localparam int DIST_W  = 30;
  localparam int CNT_W   = 6;

  localparam logic [DEN_W-1:0]  CLOCK_HZ        = 27'd72000000;
  localparam logic [9:0]        MS_PER_S        = 10'd1000;
  localparam logic [7:0]        MM_PER_MS       = 8'd170;
  localparam logic [15:0]       TIMEOUT_CAPTURE = 16'hFFFF;
  localparam logic [MS_W-1:0]   MS_MAX          = 22'd4194303;
  localparam logic [15:0]       PERIOD_RESET    = 16'd65535;
  localparam logic [15:0]       PRESCALER_RESET = 16'd71;

  // steps of the shift-subtract divider, minus one
  localparam logic [CNT_W-1:0]  RATE_LAST = 6'(DEN_W - 1);
  localparam logic [CNT_W-1:0]  MS_LAST   = 6'(NUM_W - 1);

endpackage

// ----- hdl/echo_pulse_width_ranger.sv -----
// ----------------------------------------------------------------------------
// echo pulse width ranger
// times an ultrasonic echo pulse and converts it to milliseconds and distance
// ----------------------------------------------------------------------------
// usage
//   input channel: one word per event (start, overflow tick, rising edge,
//   falling edge with the captured counter). start, tick and edge words that
//   end no measurement leave the block idle with in_ready high.
//   a falling edge while high, or a tick past OVERFLOW_LIMIT, completes a
//   measurement: in_ready drops while one shift-subtract divider runs twice,
//   first 27 steps for the tick rate from the prescaler, then 34 steps for
//   ticks*1000 over that rate. the result word is then held in the output
//   register until taken.
//   if the receiver stalls, the sequencer waits in its last step, and
//   in_ready stays low through the stall.
//   config channel: always ready; write only while idle.
//   reset: period 65535, prescaler 71, waiting for a rising edge, no result.
// ----------------------------------------------------------------------------
module echo_pulse_width_ranger #(
  parameter int OVERFLOW_LIMIT = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] captured_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  overflow_count,
  output logic [15:0] capture_value,
  output logic [21:0] elapsed_ms,
  output logic [29:0] distance_mm,
  output logic        timed_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [epwr_pkg::OVF_W-1:0] LIMIT = epwr_pkg::OVF_W'(OVERFLOW_LIMIT);

  epwr_pkg::state_t state, state_next;

  logic [15:0] timer_period;
  logic [15:0] timer_prescaler;

  logic                        high_phase;
  logic [epwr_pkg::OVF_W-1:0]  overflows_seen;
  logic [15:0]                 latched_capture;
  logic                        timeout_flag;

  logic [epwr_pkg::TICKS_W-1:0] ticks;
  logic [epwr_pkg::DEN_W-1:0]   div_rem;
  logic [epwr_pkg::NUM_W-1:0]   div_quo;
  logic [epwr_pkg::DEN_W-1:0]   div_den;
  logic [epwr_pkg::CNT_W-1:0]   step_cnt;

  logic                         in_acc;
  logic                         complete;
  logic                         out_free;
  logic [epwr_pkg::DEN_W:0]     shifted;
  logic [epwr_pkg::DEN_W+1:0]   diff;
  logic                         ge;
  logic [epwr_pkg::MS_W-1:0]    ms_sat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == epwr_pkg::S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // does this word end a measurement
  always_comb begin
    complete = 1'b0;
    unique case (epwr_pkg::action_t'(action))
      epwr_pkg::ACT_OVERFLOW: complete = high_phase && (overflows_seen >= LIMIT);
      epwr_pkg::ACT_FALL:     complete = high_phase;
      default:                complete = 1'b0;
    endcase
  end

  // shared shift-subtract divider step
  assign shifted = {div_rem, div_quo[epwr_pkg::NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, div_den};
  assign ge      = !diff[epwr_pkg::DEN_W+1];

  assign ms_sat = (div_quo > epwr_pkg::NUM_W'(epwr_pkg::MS_MAX)) ?
                  epwr_pkg::MS_MAX : div_quo[epwr_pkg::MS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= epwr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      epwr_pkg::S_IDLE: begin
        if (in_acc && complete) state_next = epwr_pkg::S_TICKS;
      end
      epwr_pkg::S_TICKS: state_next = epwr_pkg::S_RATE;
      epwr_pkg::S_RATE: begin
        if (step_cnt == '0) state_next = epwr_pkg::S_LOAD;
      end
      epwr_pkg::S_LOAD: state_next = epwr_pkg::S_MS;
      epwr_pkg::S_MS: begin
        if (step_cnt == '0) state_next = epwr_pkg::S_DIST;
      end
      epwr_pkg::S_DIST: begin
        if (out_free) state_next = epwr_pkg::S_IDLE;
      end
      default: state_next = epwr_pkg::S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period    <= epwr_pkg::PERIOD_RESET;
      timer_prescaler <= epwr_pkg::PRESCALER_RESET;
    end else if (cfg_valid) begin
      unique case (epwr_pkg::reg_index_t'(cfg_index))
        epwr_pkg::REG_PERIOD:    timer_period    <= cfg_data;
        epwr_pkg::REG_PRESCALER: timer_prescaler <= cfg_data;
        default: ;
      endcase
    end
  end

  // measurement state
  always_ff @(posedge clk) begin
    if (rst) begin
      high_phase      <= 1'b0;
      overflows_seen  <= '0;
      latched_capture <= '0;
      timeout_flag    <= 1'b0;
    end else if (in_acc) begin
      unique case (epwr_pkg::action_t'(action))
        epwr_pkg::ACT_START: begin
          high_phase      <= 1'b0;
          overflows_seen  <= '0;
          latched_capture <= '0;
        end
        epwr_pkg::ACT_OVERFLOW: begin
          if (complete) begin
            latched_capture <= epwr_pkg::TIMEOUT_CAPTURE;
            timeout_flag    <= 1'b1;
            high_phase      <= 1'b0;
          end else if (high_phase) begin
            overflows_seen <= overflows_seen + epwr_pkg::OVF_W'(1);
          end
        end
        epwr_pkg::ACT_RISE: begin
          high_phase      <= 1'b1;
          overflows_seen  <= '0;
          latched_capture <= '0;
        end
        epwr_pkg::ACT_FALL: begin
          if (complete) begin
            latched_capture <= captured_count;
            timeout_flag    <= 1'b0;
            high_phase      <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // arithmetic sequence
  always_ff @(posedge clk) begin
    unique case (state)
      epwr_pkg::S_TICKS: begin
        ticks    <= epwr_pkg::TICKS_W'(overflows_seen) *
                    epwr_pkg::TICKS_W'({1'b0, timer_period} + 17'd1)
                    + epwr_pkg::TICKS_W'(latched_capture) + 25'd1;
        // dividend left-aligned so the msb shifts out first
        div_quo  <= epwr_pkg::NUM_W'(epwr_pkg::CLOCK_HZ) <<
                    (epwr_pkg::NUM_W - epwr_pkg::DEN_W);
        div_rem  <= '0;
        div_den  <= epwr_pkg::DEN_W'({1'b0, timer_prescaler} + 17'd1);
        step_cnt <= epwr_pkg::RATE_LAST;
      end
      epwr_pkg::S_RATE, epwr_pkg::S_MS: begin
        div_rem  <= ge ? diff[epwr_pkg::DEN_W-1:0] : shifted[epwr_pkg::DEN_W-1:0];
        div_quo  <= {div_quo[epwr_pkg::NUM_W-2:0], ge};
        step_cnt <= step_cnt - epwr_pkg::CNT_W'(1);
      end
      epwr_pkg::S_LOAD: begin
        // rate in ticks per second becomes the divisor
        div_den  <= div_quo[epwr_pkg::DEN_W-1:0];
        div_quo  <= epwr_pkg::NUM_W'(ticks) * epwr_pkg::NUM_W'(epwr_pkg::MS_PER_S);
        div_rem  <= '0;
        step_cnt <= epwr_pkg::MS_LAST;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == epwr_pkg::S_DIST && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == epwr_pkg::S_DIST && out_free) begin
      overflow_count <= overflows_seen[5:0];
      capture_value  <= latched_capture;
      elapsed_ms     <= ms_sat;
      distance_mm    <= epwr_pkg::DIST_W'(ms_sat) * epwr_pkg::DIST_W'(epwr_pkg::MM_PER_MS);
      timed_out      <= timeout_flag;
    end
  end

endmodule

// ----- dv/echo_pulse_width_ranger_test.sv -----
// ----------------------------------------------------------------------------
// echo pulse width ranger testbench
// drives event words (start, overflow tick, rising and falling edge) through
// the input channel under several timer settings and idling patterns, predicts
// each completed measurement and checks every result word field by field
// ----------------------------------------------------------------------------

localparam int unsigned ECHO_OVF_LIMIT = 63;

typedef struct packed {
  logic [5:0]  ovf;
  logic [15:0] cap;
  logic [21:0] ms;
  logic [29:0] dist_mm;
  logic        timeout;
} echo_result_t;

class echo_scoreboard;
  localparam longint unsigned TICK_CLOCK_HZ = 72_000_000;
  localparam longint unsigned MS_CEILING = 4_194_303;

  bit [15:0]      period;
  bit [15:0]      prescaler;
  bit             pulse_high;
  bit [7:0]       ovf_seen;
  bit [15:0]      held_cap;
  echo_result_t   awaited_echoes[$];
  int unsigned    predicted;
  int unsigned    errors;

  function new();
    period     = 16'd65535;
    prescaler  = 16'd71;
    pulse_high = 1'b0;
    ovf_seen   = '0;
    held_cap   = '0;
    predicted  = 0;
    errors     = 0;
  endfunction

  function void write_reg(epwr_pkg::reg_index_t idx, bit [15:0] value);
    if (idx == epwr_pkg::REG_PERIOD) period = value;
    else prescaler = value;
  endfunction

  function int pending();
    return awaited_echoes.size();
  endfunction

  // ticks -> whole ms -> mm, all in exact integers
  function void close_pulse(bit by_timeout);
    longint unsigned ticks;
    longint unsigned rate;
    longint unsigned ms;
    echo_result_t    r;
    ticks = 64'(ovf_seen) * (64'(period) + 64'd1) + 64'(held_cap) + 64'd1;
    rate  = TICK_CLOCK_HZ / (64'(prescaler) + 64'd1);
    ms    = (ticks * 64'd1000) / rate;
    if (ms > MS_CEILING) ms = MS_CEILING;
    r.ovf     = ovf_seen[5:0];
    r.cap     = held_cap;
    r.ms      = ms[21:0];
    r.dist_mm = 30'(ms * 64'd170);
    r.timeout = by_timeout;
    awaited_echoes.push_back(r);
    predicted++;
    pulse_high = 1'b0;
  endfunction

  // returns 0 when the word is simply ignored by the block
  function bit note_word(epwr_pkg::action_t act, bit [15:0] cap);
    case (act)
      epwr_pkg::ACT_START: begin
        pulse_high = 1'b0;
        ovf_seen   = '0;
        held_cap   = '0;
        return 1'b1;
      end
      epwr_pkg::ACT_OVERFLOW: begin
        if (!pulse_high) return 1'b0;
        if (ovf_seen >= ECHO_OVF_LIMIT) begin
          held_cap = 16'hFFFF;
          close_pulse(1'b1);
        end else begin
          ovf_seen = ovf_seen + 8'd1;
        end
        return 1'b1;
      end
      epwr_pkg::ACT_RISE: begin
        ovf_seen   = '0;
        held_cap   = '0;
        pulse_high = 1'b1;
        return 1'b1;
      end
      default: begin
        if (!pulse_high) return 1'b0;
        held_cap = cap;
        close_pulse(1'b0);
        return 1'b1;
      end
    endcase
  endfunction

  function void compare(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  function void check_word(bit [5:0] ovf, bit [15:0] cap, bit [21:0] ms,
                           bit [29:0] dist_mm, bit timeout);
    echo_result_t want;
    if (awaited_echoes.size() == 0) begin
      $error("result word with nothing expected: overflow_count %0d capture_value %0d",
             ovf, cap);
      errors++;
      return;
    end
    want = awaited_echoes.pop_front();
    compare("overflow_count", want.ovf, ovf);
    compare("capture_value", want.cap, cap);
    compare("elapsed_ms", want.ms, ms);
    compare("distance_mm", want.dist_mm, dist_mm);
    compare("timed_out", want.timeout, timeout);
  endfunction

  function void flag_leftovers();
    if (awaited_echoes.size() != 0) begin
      $error("%0d expected result words never arrived", awaited_echoes.size());
      errors += awaited_echoes.size();
    end
  endfunction
endclass

module echo_pulse_width_ranger_test;
  import epwr_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 500;
  localparam int PHASE_WORDS   = 115;
  localparam int PHASE_ECHOES  = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = ACT_START;
  logic [15:0] captured_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  overflow_count;
  logic [15:0] capture_value;
  logic [21:0] elapsed_ms;
  logic [29:0] distance_mm;
  logic        timed_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_PERIOD;
  logic [15:0] cfg_data = '0;

  echo_scoreboard sb = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_go       = 0;
  int words_done    = 0;

  echo_pulse_width_ranger #(
    .OVERFLOW_LIMIT(ECHO_OVF_LIMIT)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .captured_count (captured_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .overflow_count (overflow_count),
    .capture_value  (capture_value),
    .elapsed_ms     (elapsed_ms),
    .distance_mm    (distance_mm),
    .timed_out      (timed_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go != 0) begin
        hold_go = 0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word(overflow_count, capture_value, elapsed_ms, distance_mm, timed_out);
  end

  function automatic logic [15:0] random_cap();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // valid is left high after acceptance; the next call or a drain decides
  task automatic send_word(action_t act, logic [15:0] cap);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    action         <= act;
    captured_count <= cap;
    do @(posedge clk); while (!in_ready);
    if (sb.note_word(act, cap)) words_done++;
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // one echo: rising edge, some ticks, falling edge; now and then noise or
  // a broken sequence
  task automatic run_pulse();
    int pick;
    int n_ovf;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_word(action_t'($urandom_range(3)), random_cap());
      return;
    end
    send_word(ACT_RISE, random_cap());
    if ($urandom_range(9) == 0) begin
      if ($urandom_range(1) == 0) send_word(ACT_OVERFLOW, random_cap());
      send_word(ACT_RISE, random_cap());
    end
    pick = $urandom_range(99);
    if (pick < 60) n_ovf = $urandom_range(3);
    else if (pick < 85) n_ovf = $urandom_range(62, 4);
    else n_ovf = $urandom_range(70, 62);
    repeat (n_ovf) send_word(ACT_OVERFLOW, random_cap());
    if ($urandom_range(19) == 0) send_word(ACT_START, random_cap());
    send_word(ACT_FALL, random_cap());
  endtask

  initial begin : stimulus
    logic [15:0] per;
    logic [15:0] pre;
    int          echo_mark;
    bit          paused;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset timer settings
    send_word(ACT_START, 16'h0000);
    send_word(ACT_FALL, 16'h1234);      // falling edge while waiting
    send_word(ACT_OVERFLOW, 16'h0000);  // tick while waiting
    send_word(ACT_RISE, 16'h0000);
    send_word(ACT_FALL, 16'h0000);
    send_word(ACT_RISE, 16'hFFFF);
    send_word(ACT_OVERFLOW, 16'h5555);
    send_word(ACT_OVERFLOW, 16'hAAAA);
    send_word(ACT_FALL, 16'hFFFF);
    send_word(ACT_RISE, 16'h0000);
    send_word(ACT_RISE, 16'h0000);      // re-arm while high
    send_word(ACT_OVERFLOW, 16'h0000);
    send_word(ACT_RISE, 16'h0000);
    send_word(ACT_FALL, 16'h0005);
    send_word(ACT_RISE, 16'h0000);
    send_word(ACT_OVERFLOW, 16'h0000);
    send_word(ACT_START, 16'hFFFF);     // clear mid pulse
    send_word(ACT_FALL, 16'h00FF);
    send_word(ACT_OVERFLOW, 16'h0000);
    send_word(ACT_RISE, 16'h0000);
    send_word(ACT_FALL, 16'hA5A5);
    send_word(ACT_START, 16'h0000);

    for (int p = 0; p < 8; p++) begin
      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (p)
        0: begin per = 16'd0;     pre = 16'd0;     end
        1: begin per = 16'd65535; pre = 16'd65535; end
        3: begin per = 16'd0;     pre = 16'd65535; end
        4: begin per = 16'd65535; pre = 16'd0;     end
        5: begin per = 16'($urandom_range(65535)); pre = 16'd71; end
        7: begin per = 16'd65535; pre = 16'd71;    end
        default: begin
          per = 16'($urandom_range(65535));
          pre = 16'($urandom_range(65535));
        end
      endcase
      write_reg(REG_PERIOD, per);
      write_reg(REG_PRESCALER, pre);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 80; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 80; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      // long receiver hold-off while words keep coming
      if (p == 4) hold_go = 1;
      words_done = 0;
      echo_mark  = sb.predicted;
      paused     = 1'b0;
      while (words_done < PHASE_WORDS || sb.predicted - echo_mark < PHASE_ECHOES) begin
        run_pulse();
        if (p == 5 && !paused && words_done >= PHASE_WORDS / 2) begin
          wait_results_done();
          paused = 1'b1;
        end
      end
    end

    in_valid <= 1'b0;
    for (int n = 0; n < 20000 && sb.pending() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
